/* design/htsp_pkg.sv */
// Shared types and constants for the heightmap triangle height sampler.
package htsp_pkg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_CELL_ROWS = 2'd0,
        REG_CELL_COLS = 2'd1,
        REG_INV_WIDTH = 2'd2,
        REG_INV_DEPTH = 2'd3
    } reg_idx_t;

    localparam int IDX_W    = 6;
    localparam int FRAC_W   = 16;
    localparam int HEIGHT_W = 32;
    localparam int POS_W    = 32;
    localparam int INV_W    = 24;

    typedef struct packed {
        logic [IDX_W-1:0] cell_rows;
        logic [IDX_W-1:0] cell_cols;
        logic [INV_W-1:0] inv_width;
        logic [INV_W-1:0] inv_depth;
    } cfg_t;

    // One classified item between the front and the back.
    typedef struct packed {
        logic                is_query;
        logic [IDX_W-1:0]    wr_row;
        logic [IDX_W-1:0]    wr_col;
        logic [HEIGHT_W-1:0] wr_data;
        logic [IDX_W-1:0]    r0;
        logic [IDX_W-1:0]    r1;
        logic [IDX_W-1:0]    c0;
        logic [IDX_W-1:0]    c1;
        logic                upper;
        logic [FRAC_W-1:0]   dx;
        logic [FRAC_W-1:0]   dz;
    } cmd_t;

endpackage

/* design/htsp_queue.sv */
// Small register FIFO; the writer never pushes into a full queue.
module htsp_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = PW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/htsp_front.sv */
// Front part: accept items, scale query positions, split into cell and fraction, clamp.
module htsp_front #(
    parameter int GRID_SIDE = 64,
    parameter int QDEPTH = 4,
    localparam int QCW = $clog2(QDEPTH) + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                operation,
    input  logic [5:0]          vertex_row,
    input  logic [5:0]          vertex_col,
    input  logic signed [31:0]  vertex_height,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_z,
    input  htsp_pkg::cfg_t      cfg,
    input  logic [QCW-1:0]      q_count,
    output logic                cmd_valid,
    output htsp_pkg::cmd_t      cmd
);

    logic                accept;
    logic signed [56:0]  mul_x;
    logic signed [56:0]  mul_z;

    logic                f1_valid_reg;
    logic                f1_query_reg;
    logic                f1_wr_ok_reg;
    logic [5:0]          f1_row_reg;
    logic [5:0]          f1_col_reg;
    logic [31:0]         f1_height_reg;
    logic signed [56:0]  f1_mul_x_reg;
    logic signed [56:0]  f1_mul_z_reg;

    logic                f2_valid_reg;
    logic                cmd_valid_reg;
    htsp_pkg::cmd_t      cmd_reg;
    htsp_pkg::cmd_t      cmd_next;

    logic signed [24:0]  col0;
    logic signed [24:0]  col1;
    logic signed [24:0]  row0;
    logic signed [24:0]  row1;
    logic [5:0]          row_lim;
    logic [5:0]          col_lim;
    logic [16:0]         frac_sum;
    logic [QCW:0]        inflight;

    function automatic logic [5:0] limit_of(logic [5:0] cnt);
        logic [5:0] lim;
        lim = (cnt == 6'd0) ? 6'd0 : cnt - 6'd1;
        if (int'(lim) > GRID_SIDE - 1)
        begin
            lim = 6'(GRID_SIDE - 1);
        end
        return lim;
    endfunction

    function automatic logic [5:0] clamp_idx(logic signed [24:0] idx, logic [5:0] lim);
        logic [5:0] res;
        if (idx < 0)
        begin
            res = 6'd0;
        end
        else if (idx > $signed({19'd0, lim}))
        begin
            res = lim;
        end
        else
        begin
            res = idx[5:0];
        end
        return res;
    endfunction

    // Hold a slot in the queue for every item in flight in the front.
    assign inflight = (QCW+1)'(f1_valid_reg) + (QCW+1)'(f2_valid_reg) + (QCW+1)'(q_count);
    assign full     = (inflight >= (QCW+1)'(QDEPTH));
    assign accept   = push && !full;

    assign mul_x = pos_x * $signed({1'b0, cfg.inv_width});
    assign mul_z = pos_z * $signed({1'b0, cfg.inv_depth});

    assign col0     = f1_mul_x_reg[56:32];
    assign row0     = f1_mul_z_reg[56:32];
    assign col1     = col0 + 25'sd1;
    assign row1     = row0 + 25'sd1;
    assign row_lim  = limit_of(cfg.cell_rows);
    assign col_lim  = limit_of(cfg.cell_cols);
    assign frac_sum = {1'b0, f1_mul_x_reg[31:16]} + {1'b0, f1_mul_z_reg[31:16]};

    always_comb
    begin
        cmd_next          = '0;
        cmd_next.is_query = f1_query_reg;
        cmd_next.wr_row   = f1_row_reg;
        cmd_next.wr_col   = f1_col_reg;
        cmd_next.wr_data  = f1_height_reg;
        cmd_next.r0       = clamp_idx(row0, row_lim);
        cmd_next.r1       = clamp_idx(row1, row_lim);
        cmd_next.c0       = clamp_idx(col0, col_lim);
        cmd_next.c1       = clamp_idx(col1, col_lim);
        cmd_next.upper    = !frac_sum[16];
        cmd_next.dx       = f1_mul_x_reg[31:16];
        cmd_next.dz       = f1_mul_z_reg[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_query_reg  <= (operation == htsp_pkg::OP_QUERY);
            f1_wr_ok_reg  <= (int'(vertex_row) < GRID_SIDE) && (int'(vertex_col) < GRID_SIDE);
            f1_row_reg    <= vertex_row;
            f1_col_reg    <= vertex_col;
            f1_height_reg <= vertex_height;
            f1_mul_x_reg  <= mul_x;
            f1_mul_z_reg  <= mul_z;
        end
        if (f1_valid_reg)
        begin
            cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg  <= accept;
            f2_valid_reg  <= f1_valid_reg;
            // Drop writes outside the store here.
            cmd_valid_reg <= f1_valid_reg && (f1_query_reg || f1_wr_ok_reg);
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

/* design/htsp_back.sv */
// Back part: four parity banks of heights, corner select and triangle interpolation.
module htsp_back #(
    parameter int GRID_SIDE = 64,
    parameter int OUT_DEPTH = 8,
    localparam int OCW = $clog2(OUT_DEPTH) + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  htsp_pkg::cmd_t      q_data,
    output logic                q_pop,
    input  logic [OCW-1:0]      out_count,
    output logic                res_valid,
    output logic [31:0]         res_data
);

    localparam int SPAN       = (GRID_SIDE < 64) ? GRID_SIDE : 64;
    localparam int HALF       = (SPAN + 1) / 2;
    localparam int ABITS      = ($clog2(HALF * HALF) < 1) ? 1 : $clog2(HALF * HALF);
    localparam int BANK_DEPTH = 1 << ABITS;

    logic [31:0]         bank_q_reg [4];
    logic                do_write;
    logic [OCW+1:0]      out_inflight;

    logic                b1_valid_reg;
    logic                b1_r0p_reg;
    logic                b1_r1p_reg;
    logic                b1_c0p_reg;
    logic                b1_c1p_reg;
    logic                b1_upper_reg;
    logic [15:0]         b1_dx_reg;
    logic [15:0]         b1_dz_reg;

    logic signed [31:0]  corner_a;
    logic signed [31:0]  corner_b;
    logic signed [31:0]  corner_c;
    logic signed [31:0]  corner_d;
    logic signed [31:0]  base_next;
    logic signed [32:0]  e1_next;
    logic signed [32:0]  e2_next;
    logic [16:0]         f1_next;
    logic [16:0]         f2_next;

    logic                b2_valid_reg;
    logic signed [31:0]  b2_base_reg;
    logic signed [32:0]  b2_e1_reg;
    logic signed [32:0]  b2_e2_reg;
    logic [16:0]         b2_f1_reg;
    logic [16:0]         b2_f2_reg;

    logic signed [50:0]  p1;
    logic signed [50:0]  p2;

    logic                b3_valid_reg;
    logic signed [31:0]  b3_base_reg;
    logic signed [50:0]  b3_p1_reg;
    logic signed [50:0]  b3_p2_reg;

    logic signed [52:0]  base_ext;
    logic signed [52:0]  acc;
    logic signed [36:0]  h;

    function automatic logic [ABITS-1:0] bank_addr(logic [5:0] row, logic [5:0] col);
        return ABITS'(int'(row[5:1]) * HALF + int'(col[5:1]));
    endfunction

    // Hold back a pop while the result queue has no room for a query in flight.
    assign out_inflight = (OCW+2)'(b1_valid_reg) + (OCW+2)'(b2_valid_reg)
                        + (OCW+2)'(b3_valid_reg) + (OCW+2)'(out_count);
    assign q_pop    = !q_empty && (out_inflight < (OCW+2)'(OUT_DEPTH));
    assign do_write = q_pop && !q_data.is_query;

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        localparam logic PR = 1'((k >> 1) & 1);
        localparam logic PC = 1'(k & 1);

        logic [31:0]      mem [BANK_DEPTH];
        logic [5:0]       rd_row;
        logic [5:0]       rd_col;
        logic [ABITS-1:0] rd_addr;
        logic [ABITS-1:0] wr_addr;
        logic             wr_en;

        always_comb
        begin
            rd_row  = (q_data.r0[0] == PR) ? q_data.r0 : q_data.r1;
            rd_col  = (q_data.c0[0] == PC) ? q_data.c0 : q_data.c1;
            rd_addr = bank_addr(rd_row, rd_col);
            wr_addr = bank_addr(q_data.wr_row, q_data.wr_col);
            wr_en   = do_write && (q_data.wr_row[0] == PR) && (q_data.wr_col[0] == PC);
        end

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= q_data.wr_data;
            end
            bank_q_reg[k] <= mem[rd_addr];
        end
    end

    always_comb
    begin
        corner_a = bank_q_reg[{b1_r0p_reg, b1_c0p_reg}];
        corner_b = bank_q_reg[{b1_r0p_reg, b1_c1p_reg}];
        corner_c = bank_q_reg[{b1_r1p_reg, b1_c0p_reg}];
        corner_d = bank_q_reg[{b1_r1p_reg, b1_c1p_reg}];
        if (b1_upper_reg)
        begin
            base_next = corner_a;
            e1_next   = 33'(corner_b) - 33'(corner_a);
            e2_next   = 33'(corner_c) - 33'(corner_a);
            f1_next   = {1'b0, b1_dx_reg};
            f2_next   = {1'b0, b1_dz_reg};
        end
        else
        begin
            base_next = corner_d;
            e1_next   = 33'(corner_c) - 33'(corner_d);
            e2_next   = 33'(corner_b) - 33'(corner_d);
            f1_next   = 17'h10000 - {1'b0, b1_dx_reg};
            f2_next   = 17'h10000 - {1'b0, b1_dz_reg};
        end
    end

    assign p1 = b2_e1_reg * $signed({1'b0, b2_f1_reg});
    assign p2 = b2_e2_reg * $signed({1'b0, b2_f2_reg});

    assign base_ext = 53'(b3_base_reg);
    assign acc      = (base_ext <<< 16) + 53'(b3_p1_reg) + 53'(b3_p2_reg);
    assign h        = acc[52:16];

    always_comb
    begin
        if ((h[36:31] == 6'b000000) || (h[36:31] == 6'b111111))
        begin
            res_data = h[31:0];
        end
        else if (h[36])
        begin
            res_data = 32'h8000_0000;
        end
        else
        begin
            res_data = 32'h7FFF_FFFF;
        end
    end

    assign res_valid = b3_valid_reg;

    always_ff @(posedge clk)
    begin
        b1_r0p_reg   <= q_data.r0[0];
        b1_r1p_reg   <= q_data.r1[0];
        b1_c0p_reg   <= q_data.c0[0];
        b1_c1p_reg   <= q_data.c1[0];
        b1_upper_reg <= q_data.upper;
        b1_dx_reg    <= q_data.dx;
        b1_dz_reg    <= q_data.dz;
        b2_base_reg  <= base_next;
        b2_e1_reg    <= e1_next;
        b2_e2_reg    <= e2_next;
        b2_f1_reg    <= f1_next;
        b2_f2_reg    <= f2_next;
        b3_base_reg  <= b2_base_reg;
        b3_p1_reg    <= p1;
        b3_p2_reg    <= p2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= q_pop && q_data.is_query;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

endmodule

/* design/heightmap_triangle_height_sample.sv */
// Top level of the heightmap triangle height sampler: config registers, front, queues, back.
// Throughput: one item per cycle, writes and queries mixed freely, unless the result queue backs up.
// A query passes in order through multiply, split/clamp, command queue, bank read, corner select,
// multiply, and sum and saturate into the result queue, where it shows as empty low.
// Reset clears all control state and loads the config defaults; the height banks
// keep undefined contents until written, with no clearing pass.
module heightmap_triangle_height_sample #(
    parameter int GRID_SIDE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               operation,
    input  logic [5:0]         vertex_row,
    input  logic [5:0]         vertex_col,
    input  logic signed [31:0] vertex_height,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] sampled_height,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    // Command queue depth covers the two front stages and the queued item plus one slot of slack,
    // so the front keeps accepting every cycle while the back keeps popping.
    localparam int MIDQ_DEPTH = 4;
    localparam int MIDQ_CW    = $clog2(MIDQ_DEPTH) + 1;
    // Result queue depth covers the three back stages plus queue turnaround.
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH) + 1;
    localparam int CMD_W      = $bits(htsp_pkg::cmd_t);

    htsp_pkg::cfg_t       cfg_reg;
    htsp_pkg::cmd_t       front_cmd;
    htsp_pkg::cmd_t       midq_head;
    logic                 front_cmd_valid;
    logic [CMD_W-1:0]     midq_head_bits;
    logic                 midq_empty;
    logic                 midq_pop;
    logic [MIDQ_CW-1:0]   midq_count;
    logic                 res_valid;
    logic [31:0]          res_data;
    logic [31:0]          outq_head;
    logic [OUTQ_CW-1:0]   outq_count;

    // Configuration transactions are always taken; the user must keep the block idle when they arrive (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_rows <= 6'd63;
            cfg_reg.cell_cols <= 6'd63;
            cfg_reg.inv_width <= 24'd65536;
            cfg_reg.inv_depth <= 24'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (htsp_pkg::reg_idx_t'(cfg_index))
                htsp_pkg::REG_CELL_ROWS: cfg_reg.cell_rows <= cfg_data[5:0];
                htsp_pkg::REG_CELL_COLS: cfg_reg.cell_cols <= cfg_data[5:0];
                htsp_pkg::REG_INV_WIDTH: cfg_reg.inv_width <= cfg_data;
                htsp_pkg::REG_INV_DEPTH: cfg_reg.inv_depth <= cfg_data;
            endcase
        end
    end

    // Front: accept, scale the position, split into cell and fraction, clamp
    // the four corner indices and pick the triangle. Writes inside the store pass through as-is.
    htsp_front #(
        .GRID_SIDE (GRID_SIDE),
        .QDEPTH    (MIDQ_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .vertex_row    (vertex_row),
        .vertex_col    (vertex_col),
        .vertex_height (vertex_height),
        .pos_x         (pos_x),
        .pos_z         (pos_z),
        .cfg           (cfg_reg),
        .q_count       (midq_count),
        .cmd_valid     (front_cmd_valid),
        .cmd           (front_cmd)
    );

    // Command queue: decouples the front from the back, keeps writes and
    // queries in order so a read always sees every earlier write.
    htsp_queue #(
        .WIDTH (CMD_W),
        .DEPTH (MIDQ_DEPTH)
    ) u_midq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_cmd_valid),
        .push_data (front_cmd),
        .pop       (midq_pop),
        .pop_data  (midq_head_bits),
        .empty     (midq_empty),
        .count     (midq_count)
    );

    assign midq_head = htsp_pkg::cmd_t'(midq_head_bits);

    // Back: the store is split into four banks by row and column parity, so
    // all four corners come out of one read; then interpolate.
    htsp_back #(
        .GRID_SIDE (GRID_SIDE),
        .OUT_DEPTH (OUTQ_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (midq_empty),
        .q_data    (midq_head),
        .q_pop     (midq_pop),
        .out_count (outq_count),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Result queue: the consumer pops at its own pace; the back only pops a
    // command when a slot is reserved for its result.
    htsp_queue #(
        .WIDTH (32),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .pop       (pop),
        .pop_data  (outq_head),
        .empty     (empty),
        .count     (outq_count)
    );

    assign sampled_height = outq_head;

`ifndef NO_ASSERTIONS
    // The credit check in the back must keep the result queue from overflowing.
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (outq_count < OUTQ_CW'(OUTQ_DEPTH)))
        else $error("result pushed into a full result queue");

    // The front's reservation must keep the command queue from overflowing.
    a_midq_room: assert property (@(posedge clk) disable iff (!rst_n)
        front_cmd_valid |-> (midq_count < MIDQ_CW'(MIDQ_DEPTH)))
        else $error("command pushed into a full command queue");

    // With no result arriving and no pop, the waiting result count holds.
    a_outq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid && !(pop && !empty)) |=> $stable(outq_count))
        else $error("result queue count changed without a transaction");
`endif

endmodule
